>>> sv/glb_pkg.sv
// Shared definitions for the gray layer blend unit: mode codes, register
// indexes and the rounded divide-by-255 product finish. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package glb_pkg;

	// Blend mode codes in table order.
	typedef enum logic [4:0] {
		MODE_NORMAL     = 5'd0,
		MODE_DISSOLVE   = 5'd1,
		MODE_BEHIND     = 5'd2,
		MODE_MULTIPLY   = 5'd3,
		MODE_SCREEN     = 5'd4,
		MODE_OVERLAY    = 5'd5,
		MODE_DIFFERENCE = 5'd6,
		MODE_ADDITION   = 5'd7,
		MODE_SUBTRACT   = 5'd8,
		MODE_DARKEN     = 5'd9,
		MODE_LIGHTEN    = 5'd10,
		MODE_HUE        = 5'd11,
		MODE_SATURATION = 5'd12,
		MODE_COLOR      = 5'd13,
		MODE_VALUE      = 5'd14,
		MODE_DIVIDE     = 5'd15,
		MODE_DODGE      = 5'd16,
		MODE_BURN       = 5'd17,
		MODE_HARDLIGHT  = 5'd18,
		MODE_ERASE      = 5'd19,
		MODE_REPLACE    = 5'd20,
		MODE_ANTI_ERASE = 5'd21
	} mode_t;

	// Configuration register indexes.
	localparam logic REG_BLEND_MODE  = 1'b0;
	localparam logic REG_LAYER_ALPHA = 1'b1;

	// Finishes a rounded divide-by-255 product: ((t >> 8) + t) >> 8, t = p + 0x80.
	function automatic logic [9:0] mul255_fin(input logic [17:0] p);
		logic [19:0] t;
		logic [19:0] s;
		begin
			t = {2'b00, p} + 20'h80;
			s = (t >> 8) + t;
			mul255_fin = s[17:8];
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/glb_div2.sv
// Two restoring division steps of the pipelined quotient unit.
// Depends on nothing; the top level chains four of these between stages.
`timescale 1ns / 1ps
`default_nettype none

module glb_div2 (
	input  wire logic [8:0] rem,
	input  wire logic [8:0] den,
	input  wire logic [7:0] quo,
	output logic [8:0]      rem_out,
	output logic [7:0]      quo_out
);
	logic [9:0] r1;
	logic [9:0] r2;
	logic [8:0] m1;
	logic       b1;
	logic       b2;

	// The remainder stays below the divisor, so each step yields one bit.
	always_comb begin
		r1 = {rem, 1'b0};
		b1 = (r1 >= {1'b0, den});
		m1 = b1 ? 9'(r1 - {1'b0, den}) : r1[8:0];
		r2 = {m1, 1'b0};
		b2 = (r2 >= {1'b0, den});
		rem_out = b2 ? 9'(r2 - {1'b0, den}) : r2[8:0];
		quo_out = {quo[5:0], b1, b2};
	end

endmodule

`default_nettype wire

>>> sv/gray_layer_blend_unit.sv
// Top level of the gray layer blend unit: five-stage pixel pipeline.
// Depends on glb_pkg and glb_div2.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | base, layer, alpha in tdata; row end in tlast
//  m_*     | out | m_tvalid/m_tready | value, alpha in tdata; alpha flag in tuser; tlast
//  cfg_*   | in  | cfg_we            | register index and data
//
// One word is taken per cycle unless the output stalls; a word moves through
// stages 1 to 5 in turn. The quotient unit takes two bits per stage over four stages.
// Reset clears the valid bits and the registers to normal mode, no alpha.
// A stall at the output freezes every stage at once; s_tready follows it.
`timescale 1ns / 1ps
`default_nettype none

module gray_layer_blend_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // base_value[7:0], layer_value[15:8], layer_alpha[23:16]
	input  wire logic        s_tlast,  // last_pixel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // result_value[7:0], result_alpha[15:8]
	output logic             m_tuser,  // alpha_affected
	output logic             m_tlast,  // last_pixel_out
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);
	import glb_pkg::*;

	logic [4:0] mode_q;
	logic       has_alpha_q;
	logic       en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			has_alpha_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_MODE:  mode_q      <= cfg_data;
				REG_LAYER_ALPHA: has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless the output word is held.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1 operand preparation.
	logic [7:0] in_b, in_l;
	logic [8:0] x_d, d_d, opa_d;
	logic [7:0] opb_d;
	logic       aff_d;

	always_comb begin
		in_b = s_tdata[7:0];
		in_l = s_tdata[15:8];
		x_d  = (mode_q == MODE_BURN) ? {1'b0, ~in_b} : {1'b0, in_b};
		d_d  = (mode_q == MODE_DODGE) ? 9'(9'd256 - {1'b0, in_l})
		                              : 9'({1'b0, in_l} + 9'd1);
		case (mode_q)
			MODE_SCREEN: begin
				opa_d = {1'b0, ~in_l};
				opb_d = ~in_b;
			end
			MODE_OVERLAY: begin
				opa_d = {in_l, 1'b0};
				opb_d = ~in_b;
			end
			MODE_HARDLIGHT: begin
				if (in_l > 8'd128) begin
					opa_d = {~in_l, 1'b1};
					opb_d = ~in_b;
				end else begin
					opa_d = {in_l, 1'b0};
					opb_d = in_b;
				end
			end
			default: begin
				opa_d = {1'b0, in_b};
				opb_d = in_l;
			end
		endcase
		case (mode_q)
			MODE_NORMAL, MODE_DISSOLVE, MODE_BEHIND,
			MODE_ERASE, MODE_REPLACE, MODE_ANTI_ERASE: aff_d = 1'b1;
			default: aff_d = 1'b0;
		endcase
	end

	logic       vld_s1, last_s1, aff_s1, hi_s1;
	logic [7:0] b_s1, l_s1, a_s1, opb_s1;
	logic [4:0] mode_s1;
	logic [8:0] x_s1, d_s1, opa_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1    <= in_b;
			l_s1    <= in_l;
			a_s1    <= has_alpha_q ? s_tdata[23:16] : 8'd0;
			last_s1 <= s_tlast;
			aff_s1  <= aff_d;
			mode_s1 <= mode_q;
			x_s1    <= x_d;
			d_s1    <= d_d;
			opa_s1  <= opa_d;
			opb_s1  <= opb_d;
			hi_s1   <= (in_l > 8'd128);
		end
	end

	// Stage 2: shared product, simple modes, first quotient bits.
	logic [7:0] simple_d;
	logic [8:0] rem2_d;
	logic [7:0] quo2_d;

	always_comb begin
		case (mode_s1)
			MODE_DIFFERENCE: simple_d = (b_s1 >= l_s1) ? 8'(b_s1 - l_s1) : 8'(l_s1 - b_s1);
			MODE_ADDITION: begin
				simple_d = ({1'b0, b_s1} + {1'b0, l_s1} > 9'd255) ? 8'd255
				           : 8'(b_s1 + l_s1);
			end
			MODE_SUBTRACT:   simple_d = (b_s1 >= l_s1) ? 8'(b_s1 - l_s1) : 8'd0;
			MODE_DARKEN:     simple_d = (b_s1 < l_s1) ? b_s1 : l_s1;
			MODE_LIGHTEN:    simple_d = (b_s1 > l_s1) ? b_s1 : l_s1;
			default:         simple_d = l_s1;
		endcase
	end

	glb_div2 u_div_s2 (
		.rem(x_s1), .den(d_s1), .quo(8'd0), .rem_out(rem2_d), .quo_out(quo2_d)
	);

	logic        vld_s2, last_s2, aff_s2, hi_s2, ovf_s2;
	logic [7:0]  b_s2, a_s2, val_s2, quo_s2;
	logic [4:0]  mode_s2;
	logic [8:0]  d_s2, rem_s2;
	logic [16:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2    <= b_s1;
			a_s2    <= a_s1;
			last_s2 <= last_s1;
			aff_s2  <= aff_s1;
			hi_s2   <= hi_s1;
			mode_s2 <= mode_s1;
			d_s2    <= d_s1;
			ovf_s2  <= (x_s1 >= d_s1);
			rem_s2  <= rem2_d;
			quo_s2  <= quo2_d;
			val_s2  <= simple_d;
			prod_s2 <= 17'(opa_s1 * opb_s1);
		end
	end

	// Stage 3: finish the product, build the overlay operand, next quotient bits.
	logic [9:0] m3_d;
	logic [8:0] q3_d;
	logic [7:0] val3_d;
	logic [8:0] rem3_d;
	logic [7:0] quo3_d;

	always_comb begin
		m3_d = mul255_fin({1'b0, prod_s2});
		q3_d = prod_s2[16:8];
		case (mode_s2)
			MODE_MULTIPLY: val3_d = m3_d[7:0];
			MODE_SCREEN:   val3_d = 8'(8'd255 - m3_d[7:0]);
			MODE_HARDLIGHT: begin
				if (hi_s2) begin
					val3_d = (q3_d >= 9'd255) ? 8'd0 : 8'(9'd255 - q3_d);
				end else begin
					val3_d = (q3_d > 9'd255) ? 8'd255 : q3_d[7:0];
				end
			end
			default: val3_d = val_s2;
		endcase
	end

	glb_div2 u_div_s3 (
		.rem(rem_s2), .den(d_s2), .quo(quo_s2), .rem_out(rem3_d), .quo_out(quo3_d)
	);

	logic       vld_s3, last_s3, aff_s3, ovf_s3;
	logic [7:0] b_s3, a_s3, val_s3, quo_s3;
	logic [4:0] mode_s3;
	logic [8:0] d_s3, rem_s3;
	logic [9:0] ovop_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s3    <= b_s2;
			a_s3    <= a_s2;
			last_s3 <= last_s2;
			aff_s3  <= aff_s2;
			mode_s3 <= mode_s2;
			d_s3    <= d_s2;
			ovf_s3  <= ovf_s2;
			rem_s3  <= rem3_d;
			quo_s3  <= quo3_d;
			val_s3  <= val3_d;
			ovop_s3 <= {2'b00, b_s2} + m3_d;
		end
	end

	// Stage 4: overlay's second product and the next quotient bits.
	logic [8:0] rem4_d;
	logic [7:0] quo4_d;

	glb_div2 u_div_s4 (
		.rem(rem_s3), .den(d_s3), .quo(quo_s3), .rem_out(rem4_d), .quo_out(quo4_d)
	);

	logic        vld_s4, last_s4, aff_s4, ovf_s4;
	logic [7:0]  a_s4, val_s4, quo_s4;
	logic [4:0]  mode_s4;
	logic [8:0]  d_s4, rem_s4;
	logic [17:0] ovprod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4      <= a_s3;
			last_s4   <= last_s3;
			aff_s4    <= aff_s3;
			mode_s4   <= mode_s3;
			d_s4      <= d_s3;
			ovf_s4    <= ovf_s3;
			rem_s4    <= rem4_d;
			quo_s4    <= quo4_d;
			val_s4    <= val_s3;
			ovprod_s4 <= 18'(b_s3 * ovop_s3);
		end
	end

	// Stage 5: last quotient bits and the final selection.
	logic [8:0] rem5_d;
	logic [7:0] quo5_d;
	logic [7:0] qf_d;
	logic [9:0] ov_d;
	logic [7:0] val5_d;

	glb_div2 u_div_s5 (
		.rem(rem_s4), .den(d_s4), .quo(quo_s4), .rem_out(rem5_d), .quo_out(quo5_d)
	);

	always_comb begin
		qf_d = ovf_s4 ? 8'd255 : quo5_d;
		ov_d = mul255_fin(ovprod_s4);
		case (mode_s4)
			MODE_OVERLAY:             val5_d = (ov_d > 10'd255) ? 8'd255 : ov_d[7:0];
			MODE_DIVIDE, MODE_DODGE:  val5_d = qf_d;
			MODE_BURN:                val5_d = (qf_d == 8'd255) ? 8'd0 : ~qf_d;
			default:                  val5_d = val_s4;
		endcase
	end

	logic       vld_s5, last_s5, aff_s5;
	logic [7:0] a_s5, val_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5    <= a_s4;
			last_s5 <= last_s4;
			aff_s5  <= aff_s4;
			val_s5  <= val5_d;
		end
	end

	// Output word.
	assign m_tvalid = vld_s5;
	assign m_tdata  = {a_s5, val_s5};
	assign m_tuser  = aff_s5;
	assign m_tlast  = last_s5;

	logic unused_rem;
	assign unused_rem = ^rem5_d;

endmodule

`default_nettype wire
